/* hdl/nsf_pkg.sv */
`default_nettype none

package nsf_pkg;

  // Default geometry of the sentence store
  localparam int SLOT_COUNT_DEF = 4;
  localparam int SLOT_BYTES_DEF = 128;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Input transaction kinds; code 3 is unused
  typedef enum logic [1:0] {
    KIND_RX    = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Result events
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_DONE     = 3'd2,
    EV_OVERFLOW = 3'd3,
    EV_RESTART  = 3'd4,
    EV_ACCESS   = 3'd5
  } event_e;

  // Item in flight while the store read completes
  typedef struct packed {
    event_e     ev;
    logic [1:0] slot;
    logic [7:0] len;
    logic       rd_use;
    logic       rdy;
  } stage_t;

  // Result held in the output register
  typedef struct packed {
    event_e     ev;
    logic [1:0] slot;
    logic [7:0] len;
    logic [7:0] rdata;
    logic       rdy;
  } result_t;

endpackage

`default_nettype wire

/* hdl/nmea_sentence_framer.sv */
`default_nettype none

// NMEA sentence framer.
// Input channel s_axis_*: one transaction per received UART byte, store read
// or ready-flag clear, selected by s_axis_tuser. Output channel m_axis_*:
// exactly one result transaction per input transaction, in order.
// Received bytes are framed into a ring of SLOT_COUNT slots of SLOT_BYTES
// bytes; '$' opens (or reopens) the current slot, '\n' closes it, marks it
// ready and moves to the next slot. The store is a single-port-write,
// registered-read memory.
// Pipeline: a taken input enters the read stage s1 and then the output
// register before its result is valid on m_axis (one stage for the store
// read, one for the output register).
// Throughput: one transaction per cycle while m_axis is not stalled. A
// completed sentence whose zero terminator fits in the slot holds the input
// back: the terminator goes into the store through its only write port in
// the cycle after the '\n', and s_axis_tready is low for that cycle.
// Reset clears the ready flags, the write slot and the fill count; the store
// contents stay undefined until written and need no clearing pass.
// When the receiver stalls, the output register holds its result and one
// more transaction is taken into the read stage; then s_axis_tready drops.
module nmea_sentence_framer
  import nsf_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] rx_byte, [9:8] slot_index, [16:10] byte_offset, [23:17] zero
  input  wire logic [23:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] event_slot, [9:2] sentence_length, [17:10] read_data,
  // [18] slot_ready, [23:19] zero
  output logic [23:0]      m_axis_tdata,
  // [2:0] event_res
  output logic [2:0]       m_axis_tuser
);

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW    = $clog2(SLOT_BYTES);
  localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
  localparam int AW    = $clog2(DEPTH);

  // Input field unpacking
  kind_e      in_kind;
  logic [7:0] in_byte;
  logic [1:0] in_slot;
  logic [6:0] in_offs;

  assign in_kind = kind_e'(s_axis_tuser);
  assign in_byte = s_axis_tdata[7:0];
  assign in_slot = s_axis_tdata[9:8];
  assign in_offs = s_axis_tdata[16:10];

  // Control state
  logic [SW-1:0]         wslot_q, wslot_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [SLOT_COUNT-1:0] flags_q, flags_d;
  logic                  term_pend_q, term_pend_d;
  logic [AW-1:0]         term_addr_q, term_addr_d;

  // Pipeline
  logic    s1_valid_q;
  stage_t  s1_q, s1_d;
  logic    out_valid_q;
  result_t out_q;

  logic in_acc, s1_move;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !term_pend_q && (!s1_valid_q || s1_move);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Store
  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_raddr];
    end
  end

  // Addressing
  logic [SW-1:0] slot_sel;
  logic [FW:0]   fill_inc;
  logic [AW-1:0] wr_base, rd_base;

  assign slot_sel  = (32'(in_slot) >= SLOT_COUNT) ? SW'(32'(in_slot) - SLOT_COUNT)
                                                  : SW'(in_slot);
  assign fill_inc  = {1'b0, fill_q} + 1'b1;
  assign wr_base   = AW'(wslot_q * SLOT_BYTES);
  assign rd_base   = AW'(slot_sel * SLOT_BYTES);

  // Decode the accepted transaction, update control state, drive the store
  always_comb begin
    fill_d      = fill_q;
    wslot_d     = wslot_q;
    flags_d     = flags_q;
    term_pend_d = 1'b0;
    term_addr_d = term_addr_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_base + AW'(fill_q);
    mem_wdata   = in_byte;
    mem_re      = 1'b0;
    mem_raddr   = rd_base + AW'(in_offs);
    s1_d.ev     = EV_NONE;
    s1_d.slot   = 2'(wslot_q);
    s1_d.len    = 8'd0;
    s1_d.rd_use = 1'b0;
    s1_d.rdy    = 1'b0;

    // Deferred zero terminator takes the write port in the stall cycle
    if (term_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = term_addr_q;
      mem_wdata = 8'd0;
    end

    if (in_acc) begin
      unique case (in_kind)
        KIND_RX: begin
          if (in_byte == CH_DOLLAR) begin
            s1_d.ev   = (fill_q == '0) ? EV_STORED : EV_RESTART;
            mem_we    = 1'b1;
            mem_waddr = wr_base;
            fill_d    = FW'(1);
          end else if (fill_q == '0) begin
            s1_d.ev = EV_NONE;
          end else if (in_byte == CH_NEWLINE) begin
            mem_we   = 1'b1;
            s1_d.ev  = EV_DONE;
            s1_d.len = 8'(fill_inc);
            if (32'(fill_inc) < SLOT_BYTES) begin
              term_pend_d = 1'b1;
              term_addr_d = wr_base + AW'(fill_inc);
            end
            flags_d[wslot_q] = 1'b1;
            wslot_d = (32'(wslot_q) == SLOT_COUNT - 1) ? '0 : wslot_q + 1'b1;
            fill_d  = '0;
          end else begin
            mem_we = 1'b1;
            if (32'(fill_inc) >= SLOT_BYTES) begin
              fill_d  = '0;
              s1_d.ev = EV_OVERFLOW;
            end else begin
              fill_d  = FW'(fill_inc);
              s1_d.ev = EV_STORED;
            end
          end
        end
        KIND_READ: begin
          s1_d.ev   = EV_ACCESS;
          s1_d.slot = 2'(slot_sel);
          s1_d.rdy  = flags_q[slot_sel];
          if (32'(in_offs) < SLOT_BYTES) begin
            mem_re      = 1'b1;
            s1_d.rd_use = 1'b1;
          end
        end
        KIND_CLEAR: begin
          s1_d.ev           = EV_ACCESS;
          s1_d.slot         = 2'(slot_sel);
          flags_d[slot_sel] = 1'b0;
        end
        default: begin
          s1_d.ev = EV_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q     <= '0;
      fill_q      <= '0;
      flags_q     <= '0;
      term_pend_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wslot_q     <= wslot_d;
      fill_q      <= fill_d;
      flags_q     <= flags_d;
      term_pend_q <= term_pend_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    term_addr_q <= term_addr_d;
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_q.ev    <= s1_q.ev;
      out_q.slot  <= s1_q.slot;
      out_q.len   <= s1_q.len;
      out_q.rdata <= s1_q.rd_use ? mem_rd_q : 8'd0;
      out_q.rdy   <= s1_q.rdy;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.ev;
  assign m_axis_tdata  = {5'd0, out_q.rdy, out_q.rdata, out_q.len, out_q.slot};

`ifndef NO_ASSERTIONS
  // Input side is closed while the terminator owns the write port
  a_term_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_pend_q |-> (!s_axis_tready && mem_we && mem_wdata == 8'd0))
    else $error("terminator write overlaps an accepted transaction");

  // Fill count never reaches the slot size
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) < SLOT_BYTES)
    else $error("fill count out of range");

  // A closed sentence leaves its slot marked ready
  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_kind == KIND_RX && in_byte == CH_NEWLINE && fill_q != '0)
      |=> flags_q[$past(wslot_q)])
    else $error("completed slot not marked ready");

  // An accepted transaction always lands in the read stage
  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted transaction lost");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for nmea_sentence_framer: drives byte, read, clear and
// unused-kind transactions, keeps a private copy of the slot store, ready
// flags and framing pointers, and compares every result transaction in order.
module tb
  import nsf_pkg::*;
();

  localparam int SLOTS        = SLOT_COUNT_DEF;
  localparam int SLOT_LEN     = SLOT_BYTES_DEF;
  localparam int ITEMS_TARGET = 1900;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_ITEMS   = 150;

  // Code 3 of the kind field has no meaning; the block must ignore it
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    event_e     ev;
    logic [1:0] slot;
    logic [7:0] len;
    logic [7:0] rdata;
    logic       rdy;
  } framer_result_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [7:0]     rx;
    logic [1:0]     slot;
    logic [6:0]     offs;
    logic           typed;   // use the expectation below instead of the predictor
    framer_result_t exp;
  } stim_row_t;

  localparam framer_result_t NO_RES = '{EV_NONE, 2'd0, 8'd0, 8'd0, 1'b0};

  // Directed opening: stray bytes before any '$', a restart, extreme byte
  // values inside a sentence, completion, reads of the stored sentence and
  // its terminator, flag clear, unused kind, and ignored fields held high.
  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{KIND_UNUSED, 8'hFF, 2'd3, 7'd127, 1'b1, '{EV_NONE,    2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h0A, 2'd0, 7'd0,   1'b1, '{EV_NONE,    2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'hFF, 2'd0, 7'd0,   1'b1, '{EV_NONE,    2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_CLEAR,  8'h00, 2'd3, 7'd0,   1'b1, '{EV_ACCESS,  2'd3, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h24, 2'd0, 7'd0,   1'b1, '{EV_STORED,  2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h47, 2'd0, 7'd0,   1'b1, '{EV_STORED,  2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h24, 2'd0, 7'd0,   1'b1, '{EV_RESTART, 2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h00, 2'd0, 7'd0,   1'b1, '{EV_STORED,  2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'hFF, 2'd0, 7'd0,   1'b1, '{EV_STORED,  2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h2A, 2'd0, 7'd0,   1'b1, '{EV_STORED,  2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h0A, 2'd0, 7'd0,   1'b1, '{EV_DONE,    2'd0, 8'd5, 8'd0, 1'b0}},
    '{KIND_READ,   8'h55, 2'd0, 7'd0,   1'b0, NO_RES},
    '{KIND_READ,   8'h00, 2'd0, 7'd2,   1'b0, NO_RES},
    '{KIND_READ,   8'h00, 2'd0, 7'd4,   1'b0, NO_RES},
    '{KIND_READ,   8'h00, 2'd0, 7'd5,   1'b0, NO_RES},
    '{KIND_CLEAR,  8'h00, 2'd0, 7'd0,   1'b1, '{EV_ACCESS,  2'd0, 8'd0, 8'd0, 1'b0}},
    '{KIND_READ,   8'h00, 2'd0, 7'd1,   1'b0, NO_RES},
    '{KIND_UNUSED, 8'h00, 2'd0, 7'd0,   1'b1, '{EV_NONE,    2'd1, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h24, 2'd3, 7'd127, 1'b1, '{EV_STORED,  2'd1, 8'd0, 8'd0, 1'b0}},
    '{KIND_RX,     8'h0A, 2'd0, 7'd0,   1'b1, '{EV_DONE,    2'd1, 8'd2, 8'd0, 1'b0}},
    '{KIND_READ,   8'h00, 2'd1, 7'd2,   1'b0, NO_RES},
    '{KIND_READ,   8'hFF, 2'd1, 7'd1,   1'b0, NO_RES}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // Private copy of the framer state
  logic [7:0]  store_mem [SLOTS*SLOT_LEN];
  logic        ready_q   [SLOTS];
  int unsigned wr_slot;
  int unsigned fill;
  int unsigned hi_mark   [SLOTS];  // bytes written so far from the slot start

  framer_result_t pending_results [$];
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  item_count     = 0;
  bit  steady_tail    = 1'b0;

  nmea_sentence_framer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bound the run; a hung handshake lands here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void store_put(int unsigned pos, logic [7:0] v);
    store_mem[wr_slot*SLOT_LEN + pos] = v;
    if (pos + 1 > hi_mark[wr_slot]) hi_mark[wr_slot] = pos + 1;
  endfunction

  // Advance the private state by one transaction and return its result
  function automatic framer_result_t framer_outcome(logic [1:0] k, logic [7:0] b,
                                                    logic [1:0] s, logic [6:0] o);
    framer_result_t r;
    r      = NO_RES;
    r.slot = wr_slot[1:0];
    case (k)
      KIND_RX: begin
        if (b == CH_DOLLAR) begin
          r.ev = (fill == 0) ? EV_STORED : EV_RESTART;
          store_put(0, b);
          fill = 1;
        end else if (fill == 0) begin
          r.ev = EV_NONE;
        end else if (b == CH_NEWLINE) begin
          store_put(fill, b);
          fill++;
          // terminator only when it still fits in the slot
          if (fill < SLOT_LEN) store_put(fill, 8'h00);
          r.len            = fill[7:0];
          ready_q[wr_slot] = 1'b1;
          wr_slot          = (wr_slot + 1) % SLOTS;
          fill             = 0;
          r.ev             = EV_DONE;
        end else begin
          store_put(fill, b);
          fill++;
          if (fill >= SLOT_LEN) begin
            fill = 0;
            r.ev = EV_OVERFLOW;
          end else begin
            r.ev = EV_STORED;
          end
        end
      end
      KIND_READ: begin
        r.ev    = EV_ACCESS;
        r.slot  = s;
        r.rdata = store_mem[s*SLOT_LEN + o];
        r.rdy   = ready_q[s];
      end
      KIND_CLEAR: begin
        r.ev       = EV_ACCESS;
        r.slot     = s;
        ready_q[s] = 1'b0;
      end
      default: r.ev = EV_NONE;
    endcase
    return r;
  endfunction

  // Present one transaction, hold it until taken, then log its expectation
  task automatic send_item(logic [1:0] k, logic [7:0] b, logic [1:0] s, logic [6:0] o,
                           bit typed, framer_result_t given);
    framer_result_t r;
    int gap;
    if (!steady_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {7'd0, o, s, b};
    do @(posedge clk_i); while (!s_axis_tready);
    r = framer_outcome(k, b, s, o);
    pending_results.push_back(typed ? given : r);
    item_count++;
    steady_tail = (item_count >= ITEMS_TARGET - TAIL_ITEMS);
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Noise between sentences: stray bytes, reads of written bytes, clears,
  // and the unused kind
  task automatic stray_item();
    int pick;
    int unsigned s;
    int unsigned o;
    pick = $urandom_range(0, 9);
    if (pick >= 3 && pick <= 5) begin
      // read only bytes that have been written at least once
      s = $urandom_range(0, SLOTS - 1);
      while (hi_mark[s] == 0) s = (s + 1) % SLOTS;
      if ($urandom_range(0, 1) == 0) o = hi_mark[s] - 1 - $urandom_range(0, 3) % hi_mark[s];
      else o = $urandom_range(0, hi_mark[s] - 1);
      send_item(KIND_READ, 8'($urandom), s[1:0], o[6:0], 1'b0, NO_RES);
    end else if (pick >= 6 && pick <= 7) begin
      send_item(KIND_CLEAR, 8'($urandom), 2'($urandom), 7'($urandom), 1'b0, NO_RES);
    end else if (pick == 8) begin
      send_item(KIND_UNUSED, 8'($urandom), 2'($urandom), 7'($urandom), 1'b0, NO_RES);
    end else if (pick == 9) begin
      send_item(KIND_RX, CH_NEWLINE, 2'($urandom), 7'($urandom), 1'b0, NO_RES);
    end else begin
      send_item(KIND_RX, 8'($urandom), 2'($urandom), 7'($urandom), 1'b0, NO_RES);
    end
  endtask

  // '$', body bytes free of framing characters, then '\n' if closed;
  // noise may be woven in when allowed
  task automatic send_sentence(int body, bit closed, bit noisy);
    logic [7:0] b;
    send_item(KIND_RX, CH_DOLLAR, 2'($urandom), 7'($urandom), 1'b0, NO_RES);
    for (int i = 0; i < body; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) stray_item();
      do b = 8'($urandom); while (b == CH_DOLLAR || b == CH_NEWLINE);
      send_item(KIND_RX, b, 2'($urandom), 7'($urandom), 1'b0, NO_RES);
    end
    if (closed) send_item(KIND_RX, CH_NEWLINE, 2'($urandom), 7'($urandom), 1'b0, NO_RES);
  endtask

  // Receiver: alternate ready stretches with stall bursts; always ready at the tail
  initial begin
    int  n;
    bit  rdy;
    @(posedge rst_ni);
    forever begin
      if (steady_tail || $urandom_range(0, 2) != 0) begin
        n   = $urandom_range(1, 30);
        rdy = 1'b1;
      end else begin
        n   = $urandom_range(1, 19);
        rdy = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= rdy;
      repeat (n - 1) @(negedge clk_i);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    framer_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, tuser %0h tdata %06h", $time,
                 m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.ev) begin
          mismatch_count++;
          $display("%0t: event expected %0d got %0d", $time, want.ev, m_axis_tuser);
        end
        if (m_axis_tdata[1:0] !== want.slot) begin
          mismatch_count++;
          $display("%0t: slot expected %0d got %0d", $time, want.slot, m_axis_tdata[1:0]);
        end
        if (m_axis_tdata[9:2] !== want.len) begin
          mismatch_count++;
          $display("%0t: length expected %0d got %0d", $time, want.len, m_axis_tdata[9:2]);
        end
        if (m_axis_tdata[17:10] !== want.rdata) begin
          mismatch_count++;
          $display("%0t: read data expected %02h got %02h", $time, want.rdata,
                   m_axis_tdata[17:10]);
        end
        if (m_axis_tdata[18] !== want.rdy) begin
          mismatch_count++;
          $display("%0t: ready flag expected %0b got %0b", $time, want.rdy, m_axis_tdata[18]);
        end
        if (m_axis_tdata[23:19] !== 5'd0) begin
          mismatch_count++;
          $display("%0t: pad bits expected 0 got %0h", $time, m_axis_tdata[23:19]);
        end
      end
    end
  end

  initial begin
    int  sentences;
    int  body;
    int  roll;
    bit  pressed;
    sentences = 0;
    pressed   = 1'b0;
    for (int i = 0; i < SLOTS*SLOT_LEN; i++) store_mem[i] = 8'h00;
    for (int i = 0; i < SLOTS; i++) begin
      ready_q[i] = 1'b0;
      hi_mark[i] = 0;
    end
    wr_slot = 0;
    fill    = 0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].slot,
                DIRECTED_ROWS[i].offs, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);
    drain_results();

    // First three sentences force the slot-edge cases: terminator at the last
    // byte, newline at the last byte with no room for the terminator, and a
    // slot filled up before any newline with trailing bytes dropped.
    while (item_count < ITEMS_TARGET) begin
      if (!pressed && item_count >= ITEMS_TARGET / 2) begin
        drain_results();
        pressed = 1'b1;
      end
      if (sentences < 3 || $urandom_range(0, 9) < 7) begin
        case (sentences)
          0: body = SLOT_LEN - 3;
          1: body = SLOT_LEN - 2;
          2: body = SLOT_LEN + 2;
          default: begin
            roll = $urandom_range(0, 99);
            if (roll < 80)      body = $urandom_range(0, 30);
            else if (roll < 90) body = $urandom_range(31, SLOT_LEN - 4);
            else if (roll < 95) body = $urandom_range(SLOT_LEN - 3, SLOT_LEN - 2);
            else                body = $urandom_range(SLOT_LEN - 1, SLOT_LEN + 4);
          end
        endcase
        send_sentence(body, sentences < 3 || $urandom_range(0, 9) != 0, sentences >= 3);
        sentences++;
      end else begin
        stray_item();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
